// ----- hw/rtl/payload_fragmenter_defines.svh -----
// ---------------------------------------------------------------------------
// payload_fragmenter_defines.svh
// Assertion macros used by the payload_fragmenter top level.
// ---------------------------------------------------------------------------
`ifndef PAYLOAD_FRAGMENTER_DEFINES_SVH
`define PAYLOAD_FRAGMENTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define PF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("payload_fragmenter: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define PF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("payload_fragmenter: next-cycle check failed");

`endif

// ----- hw/rtl/pf_pkg.sv -----
// ---------------------------------------------------------------------------
// pf_pkg
// Widths, constants and types shared by the payload fragmenter modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pf_pkg;

    // Packet geometry
    localparam int MAX_PACKET_BYTES = 1024;
    localparam int HEADER_BYTES     = 27;
    localparam int CHUNK_BYTES      = MAX_PACKET_BYTES - HEADER_BYTES;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 24;
    localparam int CNT_W    = 16;
    localparam int PN_W     = 32;
    localparam int TS_W     = 64;
    localparam int ID_W     = 32;
    localparam int TYPE_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int HDR_W     = HEADER_BYTES * BYTE_W;
    localparam int HDR_IDX_W = $clog2(HEADER_BYTES + 1);

    // Fragment count = ceil(len / CHUNK) via a reciprocal multiply.
    // The dividend is len + CHUNK - 1 (LEN_W + 1 bits); the shift is chosen so
    // that the reciprocal error times the largest dividend stays below 2^shift.
    localparam int DIVIDEND_W   = LEN_W + 1;
    localparam int RECIP_SHIFT  = DIVIDEND_W + $clog2(CHUNK_BYTES);
    localparam longint unsigned RECIP =
        ((64'd1 << RECIP_SHIFT) + 64'(CHUNK_BYTES) - 64'd1) / 64'(CHUNK_BYTES);
    localparam int RECIP_W = RECIP_SHIFT - $clog2(CHUNK_BYTES) + 2;
    localparam int PROD_W  = DIVIDEND_W + RECIP_W;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Input item kinds
    localparam logic ACTION_START = 1'b0;
    localparam logic ACTION_BYTE  = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CLIENT_ID     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SESSION_TOKEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_TYPE  = 2'd2;

    // One classified payload word, as handed from front to back
    typedef struct packed {
        logic              has_header;
        logic [BYTE_W-1:0] data;
        logic              frag_end;
        logic              msg_end;
        logic [CNT_W-1:0]  frag_count;
        logic [CNT_W-1:0]  frag_index;
        logic [CNT_W-1:0]  frag_len;
        logic [PN_W-1:0]   packet_number;
        logic [TS_W-1:0]   timestamp;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_status;

    typedef struct packed {
        logic [ID_W-1:0]   client_id;
        logic [ID_W-1:0]   session_token;
        logic [TYPE_W-1:0] message_type;
    } t_cfg;

endpackage

// ----- hw/rtl/pf_front.sv -----
// ---------------------------------------------------------------------------
// pf_front
// Accepts input words, tracks the open message and classifies each payload
// byte (header needed, fragment end, message end) for the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pf_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_action,
    input  logic [pf_pkg::LEN_W-1:0]    i_message_length,
    input  logic [pf_pkg::PN_W-1:0]     i_packet_number,
    input  logic [pf_pkg::TS_W-1:0]     i_timestamp_ms,
    input  logic [pf_pkg::BYTE_W-1:0]   i_payload_byte,
    input  pf_pkg::t_q_status           i_q_status,
    output pf_pkg::t_push               o_push
);

    logic                          r_open;
    logic [pf_pkg::LEN_W-1:0]      r_remaining;
    logic [pf_pkg::CNT_W-1:0]      r_left;
    logic [pf_pkg::CNT_W-1:0]      r_frag_count;
    logic [pf_pkg::CNT_W-1:0]      r_frag_index;
    logic [pf_pkg::PN_W-1:0]       r_packet_number;
    logic [pf_pkg::TS_W-1:0]       r_timestamp;

    logic                          accept;
    logic                          need_hdr;
    logic [pf_pkg::CNT_W-1:0]      this_len;
    logic [pf_pkg::CNT_W-1:0]      left_cur;
    logic [pf_pkg::CNT_W-1:0]      n_left;
    logic [pf_pkg::LEN_W-1:0]      n_remaining;
    logic                          frag_end;
    logic                          msg_end;
    logic [pf_pkg::DIVIDEND_W-1:0] dividend;
    logic [pf_pkg::PROD_W-1:0]     count_prod;

    assign o_ready = !i_q_status.full;
    assign accept  = i_valid && o_ready;

    // Classify the next payload byte of the open message
    always_comb begin
        need_hdr    = (r_left == '0);
        this_len    = (r_remaining < pf_pkg::LEN_W'(pf_pkg::CHUNK_BYTES))
                    ? r_remaining[pf_pkg::CNT_W-1:0]
                    : pf_pkg::CNT_W'(pf_pkg::CHUNK_BYTES);
        left_cur    = need_hdr ? this_len : r_left;
        n_left      = left_cur - 1'b1;
        n_remaining = r_remaining - 1'b1;
        frag_end    = (n_left == '0);
        msg_end     = (n_remaining == '0);
    end

    // Fragment count of a new message: ceil(len / CHUNK) by reciprocal
    assign dividend   = {1'b0, i_message_length}
                      + pf_pkg::DIVIDEND_W'(pf_pkg::CHUNK_BYTES - 1);
    assign count_prod = pf_pkg::PROD_W'(dividend) * pf_pkg::PROD_W'(pf_pkg::RECIP);

    // Hand classified bytes to the queue
    always_comb begin
        o_push.valid               = accept && (i_action == pf_pkg::ACTION_BYTE) && r_open;
        o_push.entry.has_header    = need_hdr;
        o_push.entry.data          = i_payload_byte;
        o_push.entry.frag_end      = frag_end;
        o_push.entry.msg_end       = msg_end;
        o_push.entry.frag_count    = r_frag_count;
        o_push.entry.frag_index    = r_frag_index;
        o_push.entry.frag_len      = this_len;
        o_push.entry.packet_number = r_packet_number;
        o_push.entry.timestamp     = r_timestamp;
    end

    // Message state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open       <= 1'b0;
            r_remaining  <= '0;
            r_left       <= '0;
            r_frag_count <= '0;
            r_frag_index <= '0;
        end else if (accept) begin
            if (i_action == pf_pkg::ACTION_START) begin
                r_open       <= (i_message_length != '0);
                r_remaining  <= i_message_length;
                r_left       <= '0;
                r_frag_index <= '0;
                r_frag_count <= count_prod[pf_pkg::RECIP_SHIFT +: pf_pkg::CNT_W];
            end else if (r_open) begin
                r_remaining <= n_remaining;
                r_left      <= msg_end ? '0 : n_left;
                r_open      <= !msg_end;
                if (frag_end) begin
                    r_frag_index <= r_frag_index + 1'b1;
                end
            end
        end
    end

    // Latch header fields of a new message
    always_ff @(posedge i_clk) begin
        if (accept && (i_action == pf_pkg::ACTION_START)) begin
            r_packet_number <= i_packet_number;
            r_timestamp     <= i_timestamp_ms;
        end
    end

endmodule

// ----- hw/rtl/pf_queue.sv -----
// ---------------------------------------------------------------------------
// pf_queue
// Short first-in first-out queue of classified words between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pf_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pf_pkg::t_push      i_push,
    input  logic               i_pop,
    output pf_pkg::t_q_status  o_status,
    output pf_pkg::t_entry     o_head
);

    localparam int PTR_W = (pf_pkg::QUEUE_DEPTH > 1) ? $clog2(pf_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(pf_pkg::QUEUE_DEPTH + 1);

    pf_pkg::t_entry     r_mem [pf_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    logic               do_push;
    logic               do_pop;

    assign o_status.valid = (r_count != '0);
    assign o_status.full  = (r_count == CNT_W'(pf_pkg::QUEUE_DEPTH));
    assign o_head         = r_mem[r_rd_ptr];
    assign do_push        = i_push.valid && !o_status.full;
    assign do_pop         = i_pop && o_status.valid;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(pf_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(pf_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Store pushed words
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

endmodule

// ----- hw/rtl/pf_back.sv -----
// ---------------------------------------------------------------------------
// pf_back
// Serialises queued words onto the output stream: the 27-byte big-endian
// header where one is due, then the payload byte, through an output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pf_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pf_pkg::t_cfg               i_cfg,
    input  pf_pkg::t_q_status          i_q_status,
    input  pf_pkg::t_entry             i_head,
    output logic                       o_pop,
    output logic                       o_tvalid,
    input  logic                       i_tready,
    output logic [pf_pkg::BYTE_W-1:0]  o_tdata,
    output logic                       o_tlast,
    output logic [1:0]                 o_tuser    // [0] fragment_start, [1] message_end
);

    logic [pf_pkg::HDR_IDX_W-1:0] r_hdr_idx;
    logic                         r_out_valid;
    logic [pf_pkg::BYTE_W-1:0]    r_out_byte;
    logic                         r_out_fs;
    logic                         r_out_fe;
    logic                         r_out_me;

    logic                         load;
    logic                         in_header;
    logic [pf_pkg::HDR_W-1:0]     hdr_vec;
    logic [pf_pkg::HDR_IDX_W-1:0] byte_sel;
    logic [pf_pkg::BYTE_W-1:0]    hdr_byte;

    assign load      = !r_out_valid || i_tready;
    assign in_header = i_head.has_header
                    && (r_hdr_idx != pf_pkg::HDR_IDX_W'(pf_pkg::HEADER_BYTES));
    assign o_pop     = load && i_q_status.valid && !in_header;

    // Header image, byte 0 in the top bits
    assign hdr_vec  = {i_cfg.client_id, i_cfg.session_token, i_head.packet_number,
                       i_head.timestamp, i_cfg.message_type, i_head.frag_count,
                       i_head.frag_index, i_head.frag_len};
    assign byte_sel = pf_pkg::HDR_IDX_W'(pf_pkg::HEADER_BYTES - 1) - r_hdr_idx;
    assign hdr_byte = hdr_vec[byte_sel * pf_pkg::BYTE_W +: pf_pkg::BYTE_W];

    // Walk the header, then drop the word from the queue with its payload byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= i_q_status.valid;
            if (i_q_status.valid) begin
                r_hdr_idx <= in_header ? r_hdr_idx + 1'b1 : '0;
            end
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (load && i_q_status.valid) begin
            if (in_header) begin
                r_out_byte <= hdr_byte;
                r_out_fs   <= (r_hdr_idx == '0);
                r_out_fe   <= 1'b0;
                r_out_me   <= 1'b0;
            end else begin
                r_out_byte <= i_head.data;
                r_out_fs   <= 1'b0;
                r_out_fe   <= i_head.frag_end;
                r_out_me   <= i_head.msg_end;
            end
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_byte;
    assign o_tlast  = r_out_fe;
    assign o_tuser  = {r_out_me, r_out_fs};

endmodule

// ----- hw/rtl/payload_fragmenter.sv -----
// ---------------------------------------------------------------------------
// payload_fragmenter
// Cuts a byte-per-word message into fragments of up to 997 payload bytes,
// each led by a 27-byte big-endian header.
// ---------------------------------------------------------------------------
// A start word (tuser 0) gives the message length, packet number and
// timestamp and emits nothing; each payload word (tuser 1) carries one byte.
// The front accepts one word per cycle whenever the two-entry queue has room,
// so input stalls only while the back end is busy: each payload byte goes out
// alone, but the first byte of each fragment goes out behind its 27-byte
// header, which is what paces the stream. Words pass through the queue and an
// output register before they reach the output stream. The fragment count is
// formed by a reciprocal multiply when the start word is taken. Configuration
// registers are read when a header is sent and are to be written only while
// the block is idle.
`timescale 1ns / 1ps

`include "payload_fragmenter_defines.svh"

module payload_fragmenter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [23:0] message_length, [55:24] packet_number, [119:56] timestamp_ms,
    // [127:120] payload_byte
    input  logic [127:0]                  s_axis_tdata,
    input  logic                          s_axis_tuser,   // [0] action
    // Output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [pf_pkg::BYTE_W-1:0]     m_axis_tdata,   // [7:0] out_byte
    output logic                          m_axis_tlast,   // fragment_end
    output logic [1:0]                    m_axis_tuser,   // [0] fragment_start, [1] message_end
    // Configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pf_pkg::ID_W-1:0]       i_cfg_data
);

    pf_pkg::t_cfg       r_cfg;
    pf_pkg::t_push      push;
    pf_pkg::t_q_status  q_status;
    pf_pkg::t_entry     q_head;
    logic               pop;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pf_pkg::REG_CLIENT_ID:     r_cfg.client_id     <= i_cfg_data;
                pf_pkg::REG_SESSION_TOKEN: r_cfg.session_token <= i_cfg_data;
                pf_pkg::REG_MESSAGE_TYPE:  r_cfg.message_type  <= i_cfg_data[pf_pkg::TYPE_W-1:0];
                default:                   r_cfg               <= r_cfg;
            endcase
        end
    end

    pf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s_axis_tvalid),
        .o_ready          (s_axis_tready),
        .i_action         (s_axis_tuser),
        .i_message_length (s_axis_tdata[23:0]),
        .i_packet_number  (s_axis_tdata[55:24]),
        .i_timestamp_ms   (s_axis_tdata[119:56]),
        .i_payload_byte   (s_axis_tdata[127:120]),
        .i_q_status       (q_status),
        .o_push           (push)
    );

    pf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_status (q_status),
        .o_head   (q_head)
    );

    pf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_status (q_status),
        .i_head     (q_head),
        .o_pop      (pop),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_tdata    (m_axis_tdata),
        .o_tlast    (m_axis_tlast),
        .o_tuser    (m_axis_tuser)
    );

    // A fragment's first header byte carries no end marks
    `PF_ASSERT_SAME(a_start_no_end, m_axis_tvalid && m_axis_tuser[0], !m_axis_tlast && !m_axis_tuser[1])
    // The last byte of a message also closes its fragment
    `PF_ASSERT_SAME(a_msg_end_frag_end, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast)
    // A full queue only ever backs up behind a pending output word
    `PF_ASSERT_SAME(a_full_has_output, !s_axis_tready, m_axis_tvalid)

endmodule

// ----- verif/payload_fragmenter_tb.sv -----
// ---------------------------------------------------------------------------
// payload_fragmenter_tb
// Self-checking bench for the payload fragmenter. A walked table of directed
// words covers stray bytes, empty and restarted messages and field extremes.
// Random message sequences follow, each burst under fresh header register
// values. Every output word is checked against an in-bench model of the
// fragment byte stream or a typed expected byte, with random back-pressure
// and input gaps until the final phase.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module payload_fragmenter_tb;

    localparam int          CLK_PERIOD    = 20;
    localparam int          RESET_CYCLES  = 10;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          BURST_ITEMS   = 40;
    localparam int          BURST_COUNT   = 4;
    localparam logic [15:0] CHUNK_LEN     = 16'(pf_pkg::CHUNK_BYTES);

    // One input word, split into its fields
    typedef struct packed {
        logic        action;
        logic [23:0] msg_len;
        logic [31:0] pkt_num;
        logic [63:0] stamp;
        logic [7:0]  pay;
    } t_frag_word;

    // One output word of a fragment
    typedef struct packed {
        logic [7:0] data;
        logic       frag_start;
        logic       frag_end;
        logic       msg_end;
    } t_frag_byte;

    // How a directed row is checked: by the model, nothing out, or one typed byte
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_ONE
    } t_row_check;

    typedef struct packed {
        t_frag_word w;
        t_row_check chk;
        logic       fe;
        logic       me;
    } t_stim_row;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [127:0]                 s_axis_tdata = '0;
    logic                         s_axis_tuser = 1'b0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [pf_pkg::BYTE_W-1:0]    m_axis_tdata;
    logic                         m_axis_tlast;
    logic [1:0]                   m_axis_tuser;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [pf_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [pf_pkg::ID_W-1:0]      i_cfg_data = '0;

    // Model state: header registers and message progress
    logic [31:0] hdr_client = '0;
    logic [31:0] hdr_token = '0;
    logic [7:0]  hdr_type = '0;
    logic        msg_open = 1'b0;
    logic [23:0] left_total = '0;
    logic [15:0] frag_total = '0;
    logic [15:0] frag_idx = '0;
    logic [15:0] frag_left = '0;
    logic [31:0] held_pn = '0;
    logic [63:0] held_ts = '0;

    t_frag_byte  fresh_bytes[$];
    t_frag_byte  pending_frag_bytes[$];
    t_stim_row   stim_rows[$];

    bit          stall_en = 1'b0;
    int          ready_hold = 0;
    int          useful_items = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;

    payload_fragmenter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("payload_fragmenter regression: fail");
            $finish;
        end
    end

    // Output back-pressure: random low bursts while stalling is on
    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (stall_en && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            ready_hold    <= $urandom_range(0, 2);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each accepted output word with the oldest expected byte
    always @(posedge i_clk) begin : frag_sink
        t_frag_byte want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_frag_bytes.size() == 0) begin
                $error("unexpected output word, out_byte %02h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_frag_bytes.pop_front();
                if (m_axis_tdata !== want.data) begin
                    $error("out_byte expected %02h actual %02h", want.data, m_axis_tdata);
                    mismatch_count++;
                end
                if (m_axis_tuser[0] !== want.frag_start) begin
                    $error("fragment_start expected %0b actual %0b",
                           want.frag_start, m_axis_tuser[0]);
                    mismatch_count++;
                end
                if (m_axis_tlast !== want.frag_end) begin
                    $error("fragment_end expected %0b actual %0b", want.frag_end, m_axis_tlast);
                    mismatch_count++;
                end
                if (m_axis_tuser[1] !== want.msg_end) begin
                    $error("message_end expected %0b actual %0b", want.msg_end, m_axis_tuser[1]);
                    mismatch_count++;
                end
            end
        end
    end

    // Work out the output bytes one input word causes; flag words that are dropped
    function automatic void build_fragment_bytes(input t_frag_word w, output bit dropped);
        logic [pf_pkg::HDR_W-1:0] hdr;
        logic [15:0]              this_len;
        int unsigned              frags;
        t_frag_byte               b;
        int                       i;
        fresh_bytes.delete();
        dropped = 1'b0;
        if (w.action == pf_pkg::ACTION_START) begin
            frags      = (32'(w.msg_len) + pf_pkg::CHUNK_BYTES - 1) / pf_pkg::CHUNK_BYTES;
            left_total = w.msg_len;
            frag_total = frags[15:0];
            frag_idx   = '0;
            frag_left  = '0;
            held_pn    = w.pkt_num;
            held_ts    = w.stamp;
            msg_open   = (w.msg_len != 0);
        end else if (!msg_open) begin
            dropped = 1'b1;
        end else begin
            // First byte of a fragment: emit the big-endian header ahead of it
            if (frag_left == 0) begin
                this_len = (left_total < pf_pkg::CHUNK_BYTES) ? left_total[15:0] : CHUNK_LEN;
                hdr = {hdr_client, hdr_token, held_pn, held_ts, hdr_type,
                       frag_total, frag_idx, this_len};
                for (i = 0; i < pf_pkg::HEADER_BYTES; i++) begin
                    b.data       = hdr[pf_pkg::HDR_W - 1 - 8 * i -: 8];
                    b.frag_start = (i == 0);
                    b.frag_end   = 1'b0;
                    b.msg_end    = 1'b0;
                    fresh_bytes.insert(fresh_bytes.size(), b);
                end
                frag_left = this_len;
            end
            frag_left    = frag_left - 1'b1;
            left_total   = left_total - 1'b1;
            b.data       = w.pay;
            b.frag_start = 1'b0;
            b.frag_end   = (frag_left == 0);
            b.msg_end    = (left_total == 0);
            fresh_bytes.insert(fresh_bytes.size(), b);
            if (b.frag_end)
                frag_idx = frag_idx + 1'b1;
            if (b.msg_end) begin
                msg_open  = 1'b0;
                frag_left = '0;
            end
        end
    endfunction

    function automatic t_frag_word random_word(input logic act);
        t_frag_word w;
        w.action  = act;
        w.msg_len = 24'($urandom);
        w.pkt_num = $urandom;
        w.stamp   = {$urandom, $urandom};
        w.pay     = 8'($urandom);
        return w;
    endfunction

    // Present one word, hold it until taken, then queue what it should produce
    task automatic send_word(input t_frag_word w, input t_row_check chk,
                             input logic fe, input logic me);
        t_frag_byte typed;
        bit         dropped;
        if (stall_en && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {w.pay, w.stamp, w.pkt_num, w.msg_len};
        s_axis_tuser  <= w.action;
        do @(posedge i_clk); while (!s_axis_tready);
        build_fragment_bytes(w, dropped);
        if (!dropped)
            useful_items++;
        case (chk)
            CHK_MODEL: begin
                foreach (fresh_bytes[i])
                    pending_frag_bytes.insert(pending_frag_bytes.size(), fresh_bytes[i]);
            end
            CHK_ONE: begin
                typed.data       = w.pay;
                typed.frag_start = 1'b0;
                typed.frag_end   = fe;
                typed.msg_end    = me;
                pending_frag_bytes.insert(pending_frag_bytes.size(), typed);
            end
            default: ;
        endcase
    endtask

    task automatic send_random_byte();
        send_word(random_word(pf_pkg::ACTION_BYTE), CHK_MODEL, 1'b0, 1'b0);
    endtask

    // Drop valid, let every expected byte arrive, then allow the pipeline to empty
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (pending_frag_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all three header registers, holding valid high across the writes
    task automatic load_header_regs(input logic [31:0] cid, input logic [31:0] tok,
                                    input logic [31:0] mtype);
        logic [pf_pkg::CFG_IDX_W-1:0] idx [3];
        logic [31:0]                  val [3];
        int                           k;
        idx[0] = pf_pkg::REG_CLIENT_ID;
        idx[1] = pf_pkg::REG_SESSION_TOKEN;
        idx[2] = pf_pkg::REG_MESSAGE_TYPE;
        val[0] = cid;
        val[1] = tok;
        val[2] = mtype;
        for (k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx[k])
                pf_pkg::REG_CLIENT_ID:     hdr_client = val[k];
                pf_pkg::REG_SESSION_TOKEN: hdr_token  = val[k];
                pf_pkg::REG_MESSAGE_TYPE:  hdr_type   = val[k][7:0];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_row(input logic act, input logic [23:0] len, input logic [31:0] pn,
                           input logic [63:0] ts, input logic [7:0] pay,
                           input t_row_check chk, input logic fe, input logic me);
        t_stim_row r;
        r.w.action  = act;
        r.w.msg_len = len;
        r.w.pkt_num = pn;
        r.w.stamp   = ts;
        r.w.pay     = pay;
        r.chk       = chk;
        r.fe        = fe;
        r.me        = me;
        stim_rows.insert(stim_rows.size(), r);
    endtask

    // Random message sequences: mostly complete messages, some cut short,
    // some huge and abandoned, plus stray bytes as noise
    task automatic run_random_burst(input int target);
        t_frag_word w;
        int         pick;
        int         n_send;
        int         k;
        while (useful_items < target) begin
            pick = $urandom_range(0, 19);
            w    = random_word(pf_pkg::ACTION_START);
            if (pick < 13)
                w.msg_len = 24'($urandom_range(1, 12));
            else if (pick < 15)
                w.msg_len = '0;
            else if (pick < 18)
                w.msg_len = 24'($urandom_range(13, 40));
            send_word(w, CHK_MODEL, 1'b0, 1'b0);
            if (pick >= 18)
                n_send = $urandom_range(1, 4);
            else if ($urandom_range(0, 7) == 0)
                n_send = $urandom_range(0, w.msg_len);
            else
                n_send = w.msg_len;
            for (k = 0; k < n_send; k++)
                send_random_byte();
            if ($urandom_range(0, 5) == 0)
                send_random_byte();
        end
    endtask

    initial begin : main
        int p;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        stall_en = 1'b1;

        // Directed words, header registers still at their reset values
        add_row(pf_pkg::ACTION_BYTE,  24'd0,       32'h0,         64'h0,        8'hA5,
                CHK_NONE,  1'b0, 1'b0);   // stray byte after reset
        add_row(pf_pkg::ACTION_START, 24'd0,       32'h0000_0001, 64'h1,        8'h00,
                CHK_NONE,  1'b0, 1'b0);   // empty message
        add_row(pf_pkg::ACTION_BYTE,  24'd0,       32'h0,         64'h0,        8'h5A,
                CHK_NONE,  1'b0, 1'b0);   // still stray
        add_row(pf_pkg::ACTION_START, 24'd3,       32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                8'h00, CHK_NONE,  1'b0, 1'b0);
        add_row(pf_pkg::ACTION_BYTE,  24'd0,       32'h0,         64'h0,        8'h00,
                CHK_MODEL, 1'b0, 1'b0);   // header plus first byte
        add_row(pf_pkg::ACTION_BYTE,  24'd0,       32'h0,         64'h0,        8'hFF,
                CHK_ONE,   1'b0, 1'b0);
        add_row(pf_pkg::ACTION_BYTE,  24'd0,       32'h0,         64'h0,        8'h80,
                CHK_ONE,   1'b1, 1'b1);
        add_row(pf_pkg::ACTION_BYTE,  24'd0,       32'h0,         64'h0,        8'h11,
                CHK_NONE,  1'b0, 1'b0);   // byte after the message closed
        add_row(pf_pkg::ACTION_START, 24'd1,       32'h0,         64'h0,        8'h00,
                CHK_NONE,  1'b0, 1'b0);
        add_row(pf_pkg::ACTION_BYTE,  24'd0,       32'h0,         64'h0,        8'h01,
                CHK_MODEL, 1'b0, 1'b0);   // single-byte message
        add_row(pf_pkg::ACTION_START, 24'hFF_FFFF, 32'h8000_0001, 64'h8000_0000_0000_0001,
                8'h00, CHK_NONE,  1'b0, 1'b0);   // longest message
        add_row(pf_pkg::ACTION_BYTE,  24'd0,       32'h0,         64'h0,        8'h7F,
                CHK_MODEL, 1'b0, 1'b0);
        add_row(pf_pkg::ACTION_BYTE,  24'd0,       32'h0,         64'h0,        8'hFE,
                CHK_ONE,   1'b0, 1'b0);
        add_row(pf_pkg::ACTION_START, 24'd2,       32'h1234_5678, 64'h0123_4567_89AB_CDEF,
                8'h00, CHK_NONE,  1'b0, 1'b0);   // restart abandons the long message
        add_row(pf_pkg::ACTION_BYTE,  24'd0,       32'h0,         64'h0,        8'h55,
                CHK_MODEL, 1'b0, 1'b0);
        add_row(pf_pkg::ACTION_BYTE,  24'd0,       32'h0,         64'h0,        8'hAA,
                CHK_ONE,   1'b1, 1'b1);
        add_row(pf_pkg::ACTION_START, 24'd5,       32'hDEAD_0005, 64'h5,        8'h00,
                CHK_NONE,  1'b0, 1'b0);
        add_row(pf_pkg::ACTION_BYTE,  24'd0,       32'h0,         64'h0,        8'h3C,
                CHK_MODEL, 1'b0, 1'b0);
        add_row(pf_pkg::ACTION_START, 24'd0,       32'h0,         64'h0,        8'h00,
                CHK_NONE,  1'b0, 1'b0);   // restart into an empty message
        add_row(pf_pkg::ACTION_BYTE,  24'd0,       32'h0,         64'h0,        8'hC3,
                CHK_NONE,  1'b0, 1'b0);
        foreach (stim_rows[i])
            send_word(stim_rows[i].w, stim_rows[i].chk, stim_rows[i].fe, stim_rows[i].me);
        wait_quiet();

        // Random bursts, each under fresh register values; the last runs without idling
        for (p = 0; p < BURST_COUNT; p++) begin
            if (p == 0)
                load_header_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            else if (p == 1)
                load_header_regs(32'h0, 32'hFFFF_FFFF, 32'h0);
            else
                load_header_regs($urandom, $urandom, $urandom);
            stall_en = (p != BURST_COUNT - 1);
            run_random_burst(useful_items + BURST_ITEMS);
            wait_quiet();
        end

        if (mismatch_count == 0)
            $display("payload_fragmenter regression: pass");
        else
            $display("payload_fragmenter regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/pf_pkg.sv
hw/rtl/pf_front.sv
hw/rtl/pf_queue.sv
hw/rtl/pf_back.sv
hw/rtl/payload_fragmenter.sv
verif/payload_fragmenter_tb.sv
